@@ rtl/tbc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types, codes and fixed-point helpers of the tile barycentre unit.
// ----------------------------------------------------------------------------
package tbc_pkg;

    localparam int unsigned MAX_TILES_PER_EDGE = 256;
    localparam int unsigned TPE_W              = 9;
    localparam int unsigned CMDQ_DEPTH         = 2;

    localparam logic REQ_FACE = 1'b0;
    localparam logic REQ_TILE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // normalisation targets
    localparam logic [1:0] NT_U = 2'd0;
    localparam logic [1:0] NT_F = 2'd1;
    localparam logic [1:0] NT_N = 2'd2;

    typedef logic [2:0][31:0] t_vec;

    typedef struct packed {
        logic        req_type;
        logic [15:0] tile_index;
        t_vec        v0;
        t_vec        v1;
        t_vec        v2;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [1:0]         status;
    } t_res;

    typedef enum logic [5:0] {
        S_IDLE, S_FAIL,
        S_NLOAD, S_NTOP, S_NSHIFT, S_NSQM, S_NSQA, S_NDIVS, S_NSTORE,
        S_XM1, S_XA1, S_XM2, S_XA2, S_DM, S_DA,
        S_QCHK, S_QRANGE, S_QRSQ, S_QREM,
        S_QM1, S_QA1, S_QM2, S_QA2, S_QU, S_QM3, S_QA3, S_QV,
        S_PM1, S_PA1, S_PM2, S_PA2,
        S_OUT, S_SQRT, S_DIV
    } t_state;

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    // round to nearest, halves away from zero, dropping 30 fraction bits
    function automatic logic signed [63:0] shr_round30(input logic signed [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        m = mag64(x);
        r = (m + (64'd1 << 29)) >> 30;
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

@@ rtl/tbc_front.sv @@
// ----------------------------------------------------------------------------
// tbc_front
// Input side: takes words in and queues them for the arithmetic engine.
// ----------------------------------------------------------------------------
module tbc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  tbc_pkg::t_cmd i_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop,
    output tbc_pkg::t_cmd o_cmd
);
    import tbc_pkg::*;

    localparam int unsigned PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr, w_rd;

    assign o_full      = (r_cnt == CNT_W'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    // store word
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/tbc_back.sv @@
// ----------------------------------------------------------------------------
// tbc_back
// Arithmetic engine: frame build on face loads, barycentre on tile queries,
// around one shared multiplier, a bit-serial divider and a bit-pair sqrt.
// ----------------------------------------------------------------------------
module tbc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_pop,
    input  tbc_pkg::t_cmd              i_cmd,
    input  logic [tbc_pkg::TPE_W-1:0]  i_tiles_per_edge,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output tbc_pkg::t_res              o_res
);
    import tbc_pkg::*;

    t_state r_state, n_state, r_ret;

    logic [1:0]         r_tgt, r_c, r_dsel;
    logic               r_xsel;
    logic signed [32:0] r_e [3];
    logic signed [32:0] r_f [3];
    logic signed [31:0] r_edge [3];
    logic signed [31:0] r_perp [3];
    logic signed [31:0] r_org [3];
    logic signed [31:0] r_pln [3];
    logic signed [31:0] r_fu [3];
    logic signed [31:0] r_nu [3];
    logic signed [63:0] r_nn [3];
    logic               r_bad;
    logic [63:0]        r_m [3];
    logic [2:0]         r_neg;
    logic [63:0]        r_top;
    logic signed [63:0] r_acc;
    logic signed [67:0] r_prod;
    // divider
    logic [63:0]        r_dnum, r_dq;
    logic [31:0]        r_dden;
    logic [32:0]        r_drem;
    logic               r_dneg;
    logic [5:0]         r_dcnt;
    // square root
    logic [63:0]        r_sx, r_sr, r_sb;
    logic [4:0]         r_scnt;
    // tile query
    logic [15:0]        r_idx;
    logic [TPE_W-1:0]   r_n;
    logic [7:0]         r_root;
    logic [10:0]        r_wu, r_wk;
    logic signed [33:0] r_ucoef, r_vcoef;
    logic signed [31:0] r_pos [3];
    logic [1:0]         r_status;

    logic signed [33:0] w_opa, w_opb;
    logic [1:0]         w_ia, w_ib;
    logic [63:0]        w_max, w_rb, w_sum;
    logic [32:0]        w_rem2;
    logic signed [63:0] w_dres, w_src [3], w_val, w_dot;
    logic [8:0]         w_rem;
    logic [7:0]         w_k, w_j;
    logic [10:0]        w_den;

    // cross-product neighbours of the current component
    assign w_ia = (r_c == 2'd2) ? 2'd0 : r_c + 2'd1;
    assign w_ib = (r_c == 2'd0) ? 2'd2 : r_c - 2'd1;

    assign w_max  = (r_m[0] > r_m[1]) ? ((r_m[0] > r_m[2]) ? r_m[0] : r_m[2])
                                      : ((r_m[1] > r_m[2]) ? r_m[1] : r_m[2]);
    assign w_rb   = r_sr + r_sb;
    assign w_rem2 = {r_drem[31:0], r_dnum[63]};
    assign w_dres = r_dneg ? -$signed(r_dq) : $signed(r_dq);
    assign w_sum  = 64'(r_acc + r_prod[63:0]);
    assign w_val  = r_acc - r_prod[63:0];
    assign w_dot  = r_acc + shr_round30(r_prod[63:0]);
    assign w_rem  = 9'(r_idx - r_prod[15:0]);
    assign w_k    = 8'(r_n - 9'(r_root) - 9'd1);
    assign w_j    = w_rem[8:1];
    assign w_den  = 11'(r_n) + {1'b0, r_n, 1'b0};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            unique case (r_tgt)
                NT_U:    w_src[c] = 64'(r_e[c]);
                NT_F:    w_src[c] = 64'(r_f[c]);
                default: w_src[c] = r_nn[c];
            endcase
        end
    end

    // select multiplier operands
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (r_state)
            S_NSQM: begin
                w_opa = {4'd0, r_m[r_c][29:0]};
                w_opb = {4'd0, r_m[r_c][29:0]};
            end
            S_XM1: begin
                w_opa = r_xsel ? 34'(r_nu[w_ia]) : 34'(r_edge[w_ia]);
                w_opb = r_xsel ? 34'(r_edge[w_ib]) : 34'(r_fu[w_ib]);
            end
            S_XM2: begin
                w_opa = r_xsel ? 34'(r_nu[w_ib]) : 34'(r_edge[w_ib]);
                w_opb = r_xsel ? 34'(r_edge[w_ia]) : 34'(r_fu[w_ia]);
            end
            S_DM: begin
                w_opa = (r_dsel == 2'd2) ? 34'(r_perp[r_c]) : 34'(r_edge[r_c]);
                w_opb = (r_dsel == 2'd0) ? 34'(r_e[r_c]) : 34'(r_f[r_c]);
            end
            S_QCHK: begin
                w_opa = 34'(r_n);
                w_opb = 34'(r_n);
            end
            S_QRSQ: begin
                w_opa = {26'd0, r_sr[7:0]};
                w_opb = {26'd0, r_sr[7:0]};
            end
            S_QM1: begin
                w_opa = {23'd0, r_wu};
                w_opb = 34'(r_pln[0]);
            end
            S_QM2: begin
                w_opa = {23'd0, r_wk};
                w_opb = 34'(r_pln[1]);
            end
            S_QM3: begin
                w_opa = {23'd0, r_wk};
                w_opb = 34'(r_pln[2]);
            end
            S_PM1: begin
                w_opa = r_ucoef;
                w_opb = 34'(r_edge[r_c]);
            end
            S_PM2: begin
                w_opa = r_vcoef;
                w_opb = 34'(r_perp[r_c]);
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_opa * w_opb;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state     = r_state;
        o_cmd_pop   = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = (i_cmd.req_type == REQ_FACE) ? S_NLOAD : S_QCHK;
                end
            end
            S_FAIL:  n_state = S_IDLE;
            S_NLOAD: n_state = S_NTOP;
            S_NTOP:  n_state = S_NSHIFT;
            S_NSHIFT: begin
                if (r_top == '0) begin
                    n_state = S_FAIL;
                end else if (r_top < (64'd1 << 29) || r_top >= (64'd1 << 30)) begin
                    n_state = S_NSHIFT;
                end else begin
                    n_state = S_NSQM;
                end
            end
            S_NSQM:   n_state = S_NSQA;
            S_NSQA:   n_state = (r_c == 2'd2) ? S_SQRT : S_NSQM;
            S_NDIVS:  n_state = S_DIV;
            S_NSTORE: begin
                if (r_c != 2'd2) begin
                    n_state = S_NDIVS;
                end else if (r_tgt == NT_U || r_tgt == NT_N) begin
                    n_state = (r_tgt == NT_U) ? S_NLOAD : S_XM1;
                end else begin
                    n_state = S_XM1;
                end
            end
            S_XM1: n_state = S_XA1;
            S_XA1: n_state = S_XM2;
            S_XM2: n_state = S_XA2;
            S_XA2: begin
                if (r_c != 2'd2) begin
                    n_state = S_XM1;
                end else begin
                    n_state = r_xsel ? S_DM : S_NLOAD;
                end
            end
            S_DM: n_state = S_DA;
            S_DA: n_state = (r_c == 2'd2 && r_dsel == 2'd2) ? S_IDLE : S_DM;
            S_QCHK:   n_state = r_bad ? S_OUT : S_QRANGE;
            S_QRANGE: n_state = (18'(r_idx) >= r_prod[17:0]) ? S_OUT : S_SQRT;
            S_QRSQ:   n_state = S_QREM;
            S_QREM:   n_state = S_QM1;
            S_QM1:    n_state = S_QA1;
            S_QA1:    n_state = S_QM2;
            S_QM2:    n_state = S_QA2;
            S_QA2:    n_state = S_DIV;
            S_QU:     n_state = S_QM3;
            S_QM3:    n_state = S_QA3;
            S_QA3:    n_state = S_DIV;
            S_QV:     n_state = S_PM1;
            S_PM1:    n_state = S_PA1;
            S_PA1:    n_state = S_PM2;
            S_PM2:    n_state = S_PA2;
            S_PA2:    n_state = (r_c == 2'd2) ? S_OUT : S_PM1;
            S_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_SQRT: n_state = (r_scnt == 5'd31) ? r_ret : S_SQRT;
            S_DIV:  n_state = (r_dcnt == 6'd63) ? r_ret : S_DIV;
            default: n_state = S_IDLE;
        endcase
    end

    // face state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad <= 1'b1;
            for (int c = 0; c < 3; c++) begin
                r_edge[c] <= '0;
                r_perp[c] <= '0;
                r_org[c]  <= '0;
                r_pln[c]  <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.req_type == REQ_FACE) begin
                        for (int c = 0; c < 3; c++) begin
                            r_org[c] <= i_cmd.v0[c];
                        end
                    end
                end
                S_FAIL: begin
                    r_bad <= 1'b1;
                    for (int c = 0; c < 3; c++) begin
                        r_edge[c] <= '0;
                        r_perp[c] <= '0;
                        r_pln[c]  <= '0;
                    end
                end
                S_NSTORE: begin
                    if (r_tgt == NT_U) begin
                        r_edge[r_c] <= w_dres[31:0];
                    end
                end
                S_XA2: begin
                    if (r_xsel) begin
                        r_perp[r_c] <= 32'(shr_round30(w_val));
                    end
                end
                S_DA: begin
                    if (r_c == 2'd2) begin
                        r_pln[r_dsel] <= sat32(w_dot);
                        if (r_dsel == 2'd2) begin
                            r_bad <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers of the engine
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_c <= '0;
                if (i_cmd_valid) begin
                    r_tgt <= NT_U;
                    r_idx <= i_cmd.tile_index;
                    if (i_tiles_per_edge == '0) begin
                        r_n <= TPE_W'(1);
                    end else if (i_tiles_per_edge > TPE_W'(MAX_TILES_PER_EDGE)) begin
                        r_n <= TPE_W'(MAX_TILES_PER_EDGE);
                    end else begin
                        r_n <= i_tiles_per_edge;
                    end
                    for (int c = 0; c < 3; c++) begin
                        r_e[c] <= 33'($signed(i_cmd.v1[c])) - 33'($signed(i_cmd.v0[c]));
                        r_f[c] <= 33'($signed(i_cmd.v2[c])) - 33'($signed(i_cmd.v0[c]));
                    end
                end
            end
            S_NLOAD: begin
                for (int c = 0; c < 3; c++) begin
                    r_m[c]   <= mag64(w_src[c]);
                    r_neg[c] <= w_src[c][63];
                end
            end
            S_NTOP: r_top <= w_max;
            // bring the largest magnitude into [2^29, 2^30)
            S_NSHIFT: begin
                r_c   <= '0;
                r_acc <= '0;
                if (r_top >= (64'd1 << 30)) begin
                    r_top <= r_top >> 1;
                    for (int c = 0; c < 3; c++) r_m[c] <= r_m[c] >> 1;
                end else if (r_top < (64'd1 << 29)) begin
                    r_top <= r_top << 1;
                    for (int c = 0; c < 3; c++) r_m[c] <= r_m[c] << 1;
                end
            end
            S_NSQA: begin
                r_acc <= $signed(w_sum);
                r_c   <= (r_c == 2'd2) ? '0 : r_c + 2'd1;
                if (r_c == 2'd2) begin
                    r_sx   <= w_sum;
                    r_sr   <= '0;
                    r_sb   <= 64'd1 << 62;
                    r_scnt <= '0;
                    r_ret  <= S_NDIVS;
                end
            end
            S_NDIVS: begin
                r_dnum <= (r_m[r_c] << 30) + {33'd0, r_sr[31:1]};
                r_dden <= r_sr[31:0];
                r_dneg <= r_neg[r_c];
                r_drem <= '0;
                r_dq   <= '0;
                r_dcnt <= '0;
                r_ret  <= S_NSTORE;
            end
            S_NSTORE: begin
                r_c <= (r_c == 2'd2) ? '0 : r_c + 2'd1;
                if (r_tgt == NT_F) r_fu[r_c] <= w_dres[31:0];
                if (r_tgt == NT_N) r_nu[r_c] <= w_dres[31:0];
                if (r_c == 2'd2) begin
                    r_xsel <= (r_tgt == NT_N);
                    if (r_tgt == NT_U) r_tgt <= NT_F;
                end
            end
            S_XA1: r_acc <= r_prod[63:0];
            S_XA2: begin
                r_c <= (r_c == 2'd2) ? '0 : r_c + 2'd1;
                if (!r_xsel) r_nn[r_c] <= w_val;
                if (r_c == 2'd2) begin
                    r_tgt  <= NT_N;
                    r_dsel <= '0;
                    r_acc  <= '0;
                end
            end
            S_DA: begin
                r_c   <= (r_c == 2'd2) ? '0 : r_c + 2'd1;
                r_acc <= (r_c == 2'd2) ? '0 : w_dot;
                if (r_c == 2'd2) begin
                    r_dsel <= r_dsel + 2'd1;
                end
            end
            S_QCHK: begin
                r_status <= ST_BAD;
                for (int c = 0; c < 3; c++) r_pos[c] <= '0;
            end
            S_QRANGE: begin
                r_status <= ST_RANGE;
                r_sx     <= 64'(r_idx);
                r_sr     <= '0;
                r_sb     <= 64'd1 << 62;
                r_scnt   <= '0;
                r_ret    <= S_QRSQ;
            end
            S_QRSQ: r_root <= r_sr[7:0];
            S_QREM: begin
                r_wu <= 11'({w_j, 1'b0}) + 11'(w_j) + 11'(w_rem[0]) + 11'd1;
                r_wk <= 11'({w_k, 1'b0}) + 11'(w_k) + 11'(w_rem[0]) + 11'd1;
            end
            S_QA1: r_acc <= r_prod[63:0];
            S_QA2, S_QA3: begin
                r_dnum <= mag64($signed(w_sum)) + 64'(w_den[10:1]);
                r_dden <= 32'(w_den);
                r_dneg <= w_sum[63];
                r_drem <= '0;
                r_dq   <= '0;
                r_dcnt <= '0;
                r_ret  <= (r_state == S_QA2) ? S_QU : S_QV;
            end
            S_QU: r_ucoef <= w_dres[33:0];
            S_QV: begin
                r_vcoef <= w_dres[33:0];
                r_c     <= '0;
            end
            S_QM3: r_acc <= '0;
            S_PA1: r_acc <= r_prod[63:0];
            S_PA2: begin
                r_pos[r_c] <= sat32(shr_round30($signed(w_sum)) + 64'(r_org[r_c]));
                r_c        <= r_c + 2'd1;
                r_status   <= ST_OK;
            end
            // one result bit from each radicand bit pair
            S_SQRT: begin
                r_scnt <= r_scnt + 5'd1;
                r_sb   <= r_sb >> 2;
                if (r_sx >= w_rb) begin
                    r_sx <= r_sx - w_rb;
                    r_sr <= (r_sr >> 1) + r_sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
            end
            // one quotient bit per cycle
            S_DIV: begin
                r_dcnt <= r_dcnt + 6'd1;
                r_dnum <= r_dnum << 1;
                if (w_rem2 >= {1'b0, r_dden}) begin
                    r_drem <= w_rem2 - {1'b0, r_dden};
                    r_dq   <= {r_dq[62:0], 1'b1};
                end else begin
                    r_drem <= w_rem2;
                    r_dq   <= {r_dq[62:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign o_res.pos_x  = r_pos[0];
    assign o_res.pos_y  = r_pos[1];
    assign o_res.pos_z  = r_pos[2];
    assign o_res.status = r_status;

endmodule

@@ rtl/triangle_tile_barycenter_top.sv @@
// ----------------------------------------------------------------------------
// triangle_tile_barycenter_top
// Tile barycentre unit: face frame store and per-tile 3D barycentre.
// ----------------------------------------------------------------------------
// A word with req_type 0 loads a face and gives no result; one with req_type 1
// gives one result. Words are queued two deep in front of a single engine that
// works on one word at a time around a shared 34x34 multiplier, a one-bit-a-
// cycle divider and a square root that takes two radicand bits a cycle.
// The divider is used twice per tile query and nine times per good face load,
// which also runs the one-bit-a-cycle normalising shifts. The result waits in
// an output register, so the next word is taken in while it is unread. The
// tiles_per_edge register is at byte address 0; the user must write it only
// while the unit is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module triangle_tile_barycenter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input queue
    input  logic                push,
    output logic                full,
    input  logic [0:0]          i_req_type,
    input  logic [15:0]         i_tile_index,
    input  logic signed [31:0]  i_v0_x,
    input  logic signed [31:0]  i_v0_y,
    input  logic signed [31:0]  i_v0_z,
    input  logic signed [31:0]  i_v1_x,
    input  logic signed [31:0]  i_v1_y,
    input  logic signed [31:0]  i_v1_z,
    input  logic signed [31:0]  i_v2_x,
    input  logic signed [31:0]  i_v2_y,
    input  logic signed [31:0]  i_v2_z,
    // result queue
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic [1:0]          o_status,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tbc_pkg::*;

    localparam logic REG_TILES_PER_EDGE = 1'b0;

    logic [TPE_W-1:0] r_tpe;
    t_res             r_out;
    logic             r_ov;
    t_cmd             w_cmd, w_qcmd;
    t_res             w_res;
    logic             w_qvalid, w_qpop, w_res_valid, w_res_ready;

    assign pready = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpe <= TPE_W'(1);
        end else if (psel && penable && pwrite && paddr[2] == REG_TILES_PER_EDGE) begin
            r_tpe <= pwdata[TPE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TILES_PER_EDGE) begin
            prdata = 32'(r_tpe);
        end
    end

    // pack the input word
    always_comb begin
        w_cmd.req_type   = i_req_type[0];
        w_cmd.tile_index = i_tile_index;
        w_cmd.v0         = {i_v0_z, i_v0_y, i_v0_x};
        w_cmd.v1         = {i_v1_z, i_v1_y, i_v1_x};
        w_cmd.v2         = {i_v2_z, i_v2_y, i_v2_x};
    end

    tbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_cmd       (w_cmd),
        .o_cmd_valid (w_qvalid),
        .i_cmd_pop   (w_qpop),
        .o_cmd       (w_qcmd)
    );

    tbc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (w_qvalid),
        .o_cmd_pop        (w_qpop),
        .i_cmd            (w_qcmd),
        .i_tiles_per_edge (r_tpe),
        .o_res_valid      (w_res_valid),
        .i_res_ready      (w_res_ready),
        .o_res            (w_res)
    );

    // hold the result word until popped
    assign w_res_ready = !r_ov || pop;

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_ov <= 1'b1;
        end else if (pop) begin
            r_ov <= 1'b0;
        end
    end

    assign empty    = !r_ov;
    assign o_pos_x  = r_out.pos_x;
    assign o_pos_y  = r_out.pos_y;
    assign o_pos_z  = r_out.pos_z;
    assign o_status = r_out.status;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Tile barycentre unit testbench
// Face loads and tile queries are fed through the input queue. Expected
// results come from a fixed-point model of the face frame and barycentre maths
// and are compared in arrival order. Both queue sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import tbc_pkg::*;

    typedef longint t_l3[3];
    typedef int     t_i3[3];
    typedef int     t_i9[9];

    typedef struct {
        logic       kind;
        bit [15:0]  idx;
        t_i9        vtx;
        bit         typed;
        logic [1:0] st;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [0:0]  i_req_type = REQ_FACE;
    logic [15:0] i_tile_index = '0;
    logic signed [31:0] i_v0_x = '0, i_v0_y = '0, i_v0_z = '0;
    logic signed [31:0] i_v1_x = '0, i_v1_y = '0, i_v1_z = '0;
    logic signed [31:0] i_v2_x = '0, i_v2_y = '0, i_v2_z = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic [1:0]  o_status;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    triangle_tile_barycenter_top dut (.*);

    always #5 i_clk = ~i_clk;

    // face frame held by the model
    t_i3      unit_u, unit_v, origin, plane;
    bit       face_invalid;
    bit [8:0] edge_tiles;

    t_res  expected_q[$];
    t_row  rows[$];
    int    errors = 0;
    int    faces_sent = 0, queries_sent = 0, results_seen = 0;
    bit    calm = 1'b0;
    bit    hold_req = 1'b0;
    int    quiet = 0;

    function automatic longint unsigned magn(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint round_shift(longint x, int s);
        longint unsigned m;
        m = (magn(x) + (64'd1 << (s - 1))) >> s;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_div(longint x, longint d);
        longint unsigned m;
        m = (magn(x) + longint'(d / 2)) / d;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // scale to [2^29, 2^30), then divide by the integer length
    function automatic bit unit_vector(input t_l3 vin, output t_i3 vout);
        longint unsigned m[3];
        longint unsigned top, total, len;
        top = 0;
        total = 0;
        vout = '{0, 0, 0};
        for (int c = 0; c < 3; c++) begin
            m[c] = magn(vin[c]);
            if (m[c] > top) top = m[c];
        end
        if (top == 0) return 1'b0;
        while (top >= (64'd1 << 30)) begin
            top = top >> 1;
            for (int c = 0; c < 3; c++) m[c] = m[c] >> 1;
        end
        while (top < (64'd1 << 29)) begin
            top = top << 1;
            for (int c = 0; c < 3; c++) m[c] = m[c] << 1;
        end
        for (int c = 0; c < 3; c++) total += m[c] * m[c];
        len = int_sqrt(total);
        for (int c = 0; c < 3; c++) begin
            m[c] = ((m[c] << 30) + len / 2) / len;
            vout[c] = vin[c] < 0 ? -int'(m[c]) : int'(m[c]);
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input t_i3 a, input t_i3 b, output t_l3 r);
        r[0] = longint'(a[1]) * b[2] - longint'(a[2]) * b[1];
        r[1] = longint'(a[2]) * b[0] - longint'(a[0]) * b[2];
        r[2] = longint'(a[0]) * b[1] - longint'(a[1]) * b[0];
    endfunction

    function automatic int frame_dot(input t_i3 u, input t_l3 d);
        longint s;
        s = 0;
        for (int c = 0; c < 3; c++) s += round_shift(longint'(u[c]) * d[c], 30);
        return int'(clamp32(s));
    endfunction

    // build the in-plane frame of a new face
    function automatic void load_face_model(input t_i9 v);
        t_l3 e, f, nn, vv;
        t_i3 u, fu, nu, w;
        bit  good;
        for (int c = 0; c < 3; c++) begin
            origin[c] = v[c];
            e[c] = longint'(v[3 + c]) - v[c];
            f[c] = longint'(v[6 + c]) - v[c];
        end
        good = unit_vector(e, u);
        if (good) good = unit_vector(f, fu);
        if (good) begin
            cross3(u, fu, nn);
            good = unit_vector(nn, nu);
        end
        if (!good) begin
            unit_u = '{0, 0, 0};
            unit_v = '{0, 0, 0};
            plane = '{0, 0, 0};
            face_invalid = 1'b1;
            return;
        end
        cross3(nu, u, vv);
        for (int c = 0; c < 3; c++) w[c] = int'(round_shift(vv[c], 30));
        unit_u = u;
        unit_v = w;
        plane[0] = frame_dot(u, e);
        plane[1] = frame_dot(u, f);
        plane[2] = frame_dot(w, f);
        face_invalid = 1'b0;
    endfunction

    function automatic t_res tile_barycentre(bit [15:0] idx);
        t_res   r;
        longint n, root, rem, i, j, k, wu, wk, uc, vc;
        longint p[3];
        p = '{0, 0, 0};
        r.status = ST_OK;
        n = edge_tiles == 0 ? 1 : (edge_tiles > MAX_TILES_PER_EDGE ?
                                   MAX_TILES_PER_EDGE : edge_tiles);
        if (face_invalid) begin
            r.status = ST_BAD;
        end else if (idx >= n * n) begin
            r.status = ST_RANGE;
        end else begin
            root = int_sqrt(idx);
            rem = idx - root * root;
            k = n - root - 1;
            j = rem / 2;
            i = rem - 2 * j;
            wu = 3 * j + i + 1;
            wk = 3 * k + i + 1;
            uc = round_div(wu * plane[0] + wk * plane[1], 3 * n);
            vc = round_div(wk * plane[2], 3 * n);
            for (int c = 0; c < 3; c++)
                p[c] = clamp32(round_shift(uc * unit_u[c] + vc * unit_v[c], 30) + origin[c]);
        end
        r.pos_x = p[0][31:0];
        r.pos_y = p[1][31:0];
        r.pos_z = p[2][31:0];
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // offer one word and wait for it to be taken
    task automatic send_word(input t_row w);
        int   gap;
        t_res r;
        gap = idle_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_req_type <= w.kind;
        i_tile_index <= w.idx;
        {i_v0_x, i_v0_y, i_v0_z} <= {w.vtx[0], w.vtx[1], w.vtx[2]};
        {i_v1_x, i_v1_y, i_v1_z} <= {w.vtx[3], w.vtx[4], w.vtx[5]};
        {i_v2_x, i_v2_y, i_v2_z} <= {w.vtx[6], w.vtx[7], w.vtx[8]};
        do @(posedge i_clk); while (full);
        if (w.kind == REQ_FACE) begin
            load_face_model(w.vtx);
            faces_sent++;
        end else begin
            r = tile_barycentre(w.idx);
            if (w.typed) begin
                r = '{pos_x: 0, pos_y: 0, pos_z: 0, status: w.st};
            end
            expected_q.push_back(r);
            queries_sent++;
        end
    endtask

    // let the engine drain, including a face load that gives no result
    task automatic settle();
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
    endtask

    task automatic write_tiles(input bit [8:0] val);
        settle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= {23'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        edge_tiles = val;
    endtask

    function automatic int rand_coord(bit wide);
        return wide ? int'($urandom) : int'($urandom_range(0, 1 << 23)) - (1 << 22);
    endfunction

    function automatic t_row face_row(int a0, int a1, int a2, int b0, int b1, int b2,
                                      int c0, int c1, int c2);
        t_row w;
        w.kind = REQ_FACE;
        w.idx = 16'($urandom);
        w.vtx = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        w.typed = 1'b0;
        w.st = ST_OK;
        return w;
    endfunction

    function automatic t_row query_row(bit [15:0] idx, bit typed, logic [1:0] st);
        t_row w;
        w.kind = REQ_TILE;
        w.idx = idx;
        foreach (w.vtx[c]) w.vtx[c] = int'($urandom);
        w.typed = typed;
        w.st = st;
        return w;
    endfunction

    function automatic t_row random_face();
        int  r;
        bit  wide;
        t_i9 v;
        r = $urandom_range(0, 99);
        wide = r >= 80 && r < 90;
        foreach (v[c]) v[c] = rand_coord(wide);
        if (r >= 90) begin
            case ($urandom_range(0, 2))
                0: for (int c = 0; c < 3; c++) v[3 + c] = v[c];
                1: for (int c = 0; c < 3; c++) v[6 + c] = v[c];
                default: for (int c = 0; c < 3; c++) v[6 + c] = 2 * v[3 + c] - v[c];
            endcase
        end
        return face_row(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    endfunction

    // check each popped word against the oldest expectation
    initial begin
        int   stall;
        t_res e;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (o_pos_x !== e.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", e.pos_x, o_pos_x);
                        errors++;
                    end
                    if (o_pos_y !== e.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", e.pos_y, o_pos_y);
                        errors++;
                    end
                    if (o_pos_z !== e.pos_z) begin
                        $error("pos_z: expected %0d, got %0d", e.pos_z, o_pos_z);
                        errors++;
                    end
                    if (o_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, o_status);
                        errors++;
                    end
                end
            end
            if (hold_req) begin
                pop <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                stall = idle_gap();
            end
        end
    end

    // give up when nothing moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || psel) begin
            quiet <= 0;
        end else if (quiet >= 20000) begin
            $display("triangle_tile_barycenter_top: mismatch");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        bit [8:0] settings[8];
        int       n, queries_left;
        settings = '{9'd0, 9'd256, 9'd511, 9'd3, 9'd17, 9'd100, 9'd2, 9'd1};
        unit_u = '{0, 0, 0};
        unit_v = '{0, 0, 0};
        origin = '{0, 0, 0};
        plane = '{0, 0, 0};
        face_invalid = 1'b1;
        edge_tiles = 9'd1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words, one tile per edge after reset
        rows.push_back(query_row(16'd0, 1'b1, ST_BAD));
        rows.push_back(face_row(5, 6, 7, 5, 6, 7, 100, 0, 0));
        rows.push_back(query_row(16'd0, 1'b1, ST_BAD));
        rows.push_back(face_row(0, 0, 0, 65536, 0, 0, 0, 0, 0));
        rows.push_back(query_row(16'd0, 1'b1, ST_BAD));
        rows.push_back(face_row(0, 0, 0, 65536, 0, 0, 131072, 0, 0));
        rows.push_back(query_row(16'd0, 1'b1, ST_BAD));
        rows.push_back(face_row(32'h80000000, 32'h80000000, 32'h80000000,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h80000000, 32'h7fffffff));
        rows.push_back(query_row(16'd0, 1'b0, ST_OK));
        rows.push_back(query_row(16'hffff, 1'b1, ST_RANGE));
        rows.push_back(query_row(16'd1, 1'b1, ST_RANGE));
        rows.push_back(face_row(0, 0, 0, 3 << 16, 0, 0, 0, 4 << 16, 0));
        rows.push_back(query_row(16'd0, 1'b0, ST_OK));
        rows.push_back(face_row(-(7 << 16), -3, -(1 << 20), 9 << 16, -(2 << 16), 5,
                                -(1 << 16), 6 << 16, -(4 << 16)));
        rows.push_back(query_row(16'd0, 1'b0, ST_OK));
        rows.push_back(query_row(16'h8000, 1'b1, ST_RANGE));
        foreach (rows[r]) send_word(rows[r]);

        // random phases, each a tiles_per_edge setting followed by a random mix of face loads and queries
        foreach (settings[p]) begin
            write_tiles(settings[p]);
            calm = (p == 5);
            n = settings[p] == 0 ? 1 : (settings[p] > 256 ? 256 : settings[p]);
            if (p == 3) hold_req = 1'b1;
            queries_left = 190;
            while (queries_left > 0) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_word(random_face());
                end else begin
                    send_word(query_row($urandom_range(0, 99) < 85 ?
                              16'($urandom_range(0, n * n - 1)) : 16'($urandom),
                              1'b0, ST_OK));
                    queries_left--;
                end
            end
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d face loads and %0d tile queries over %0d edge settings,",
                 faces_sent, queries_sent, $size(settings));
        $display("with %0d result words checked, including a long result-side stall.",
                 results_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("triangle_tile_barycenter_top: match");
        end else begin
            $display("triangle_tile_barycenter_top: mismatch");
        end
        $finish;
    end

endmodule
